// ===== rtl/der_pkg.sv =====
// Package for the deferred event router: parameter defaults, codes and a shared saturating-increment function.
// Used by every module of the block; depends on nothing.
package der_pkg;

    localparam int NORMAL_DEPTH   = 16;
    localparam int DEFERRED_DEPTH = 16;
    localparam int LIST_DEPTH     = 8;
    localparam int TYPE_BITS      = 8;
    localparam int HANDLE_BITS    = 16;

    localparam int CAP_BITS   = 5;
    localparam int LIMIT_BITS = 4;
    localparam int STAT_BITS  = 3;
    localparam int CNT_BITS   = 5;

    localparam logic [1:0] KIND_POST    = 2'd0;
    localparam logic [1:0] KIND_DEFER   = 2'd1;
    localparam logic [1:0] KIND_UNDEFER = 2'd2;
    localparam logic [1:0] KIND_TAKE    = 2'd3;

    localparam logic [STAT_BITS-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_FULL       = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_EMPTY      = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_NOT_LISTED = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_LIST_FULL  = 3'd4;

    localparam logic [1:0] CFG_NORMAL_CAP   = 2'd0;
    localparam logic [1:0] CFG_DEFERRED_CAP = 2'd1;
    localparam logic [1:0] CFG_LIST_LIMIT   = 2'd2;

    // Saturating increment of a result counter.
    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
        sat_inc = (v == {CNT_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

// ===== rtl/der_fifo.sv =====
// One event FIFO of the router: a synchronous memory with pointers and fill count.
// Depends on der_pkg. Pop data is registered and appears in the cycle after the pop request.
module der_fifo #(
    parameter int DEPTH  = der_pkg::NORMAL_DEPTH,
    parameter int WIDTH  = der_pkg::TYPE_BITS + der_pkg::HANDLE_BITS,
    parameter int PBITS  = $clog2(DEPTH),
    parameter int FBITS  = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [FBITS-1:0] i_cap,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output logic             o_full,
    output logic             o_empty,
    output logic [FBITS-1:0] o_fill
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    logic [PBITS-1:0] r_head, r_tail, n_head, n_tail;
    logic [FBITS-1:0] r_fill, n_fill;
    logic [PBITS-1:0] head_slot, tail_slot;
    logic [FBITS-1:0] head_inc, tail_inc;

    // A pointer at or beyond the capacity counts as slot zero.
    assign head_slot = ({1'b0, r_head} < {1'b0, i_cap}) ? r_head : '0;
    assign tail_slot = ({1'b0, r_tail} < {1'b0, i_cap}) ? r_tail : '0;
    assign head_inc  = FBITS'(head_slot) + 1'b1;
    assign tail_inc  = FBITS'(tail_slot) + 1'b1;

    assign o_full  = (r_fill >= i_cap);
    assign o_empty = (r_fill == '0);
    assign o_fill  = r_fill;
    assign o_pop_data = r_rdata;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_pop) begin
            n_head = (head_inc >= i_cap) ? '0 : head_inc[PBITS-1:0];
        end
        if (i_push) begin
            n_tail = (tail_inc >= i_cap) ? '0 : tail_inc[PBITS-1:0];
        end
        if (i_push && !i_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= PBITS'(1);
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[n_tail] <= i_push_data;
        end
        r_rdata <= r_mem[head_slot];
    end

endmodule

// ===== rtl/der_list.sv =====
// Short list of deferred event types with search, append and compacting removal.
// Depends on der_pkg.
module der_list #(
    parameter int LIST_DEPTH = der_pkg::LIST_DEPTH,
    parameter int TYPE_BITS  = der_pkg::TYPE_BITS,
    parameter int LBITS      = $clog2(LIST_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [TYPE_BITS-1:0] i_type,
    input  logic [LBITS-1:0]     i_limit,
    input  logic                 i_append,
    input  logic                 i_remove,
    output logic                 o_listed,
    output logic                 o_full
);

    logic [TYPE_BITS-1:0] r_list [LIST_DEPTH];
    logic [LBITS-1:0]     r_fill;
    logic [LIST_DEPTH-1:0] hit;
    logic [LIST_DEPTH-1:0] sel;
    logic                 found;

    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            hit[i] = (LBITS'(i) < r_fill) && (r_list[i] == i_type);
        end
    end
    assign found    = |hit;
    assign o_listed = found;
    assign o_full   = (r_fill >= i_limit);

    // Highest matching index is removed; entries above it shift down.
    always_comb begin
        sel = '0;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (hit[i]) begin
                sel = '0;
                sel[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            for (int i = 0; i < LIST_DEPTH; i++) begin
                r_list[i] <= '0;
            end
        end else if (i_append && !o_full) begin
            r_list[r_fill[$clog2(LIST_DEPTH > 1 ? LIST_DEPTH : 2)-1:0]] <= i_type;
            r_fill <= r_fill + 1'b1;
        end else if (i_remove && found) begin
            for (int i = 0; i < LIST_DEPTH; i++) begin
                if ((sel & ((LIST_DEPTH)'(1) << i)) != '0 ||
                    (|(sel & (((LIST_DEPTH)'(1) << i) - 1'b1)))) begin
                    r_list[i] <= (i + 1 < LIST_DEPTH) ? r_list[(i + 1) % LIST_DEPTH] : '0;
                end
            end
            r_fill <= r_fill - 1'b1;
        end
    end

endmodule

// ===== rtl/deferred_event_router.sv =====
// Deferred event router: top level with the sequencer, both event FIFOs and the type list.
// Depends on der_pkg, der_fifo and der_list.
// Throughput: one item at a time; a new beat is taken the cycle after the result leaves.
// Reset (synchronous, active low) resets the FIFO pointers and clears fills, the list and the sequencer.
module deferred_event_router #(
    parameter int NORMAL_DEPTH   = der_pkg::NORMAL_DEPTH,
    parameter int DEFERRED_DEPTH = der_pkg::DEFERRED_DEPTH,
    parameter int LIST_DEPTH     = der_pkg::LIST_DEPTH,
    parameter int TYPE_BITS      = der_pkg::TYPE_BITS,
    parameter int HANDLE_BITS    = der_pkg::HANDLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_kind,
    input  logic [TYPE_BITS-1:0]          i_event_type,
    input  logic [HANDLE_BITS-1:0]        i_event_handle,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [der_pkg::STAT_BITS-1:0] o_status,
    output logic                          o_went_deferred,
    output logic [HANDLE_BITS-1:0]        o_out_handle,
    output logic [TYPE_BITS-1:0]          o_out_type,
    output logic [der_pkg::CNT_BITS-1:0]  o_moved_count,
    output logic [der_pkg::CNT_BITS-1:0]  o_dropped_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [der_pkg::CAP_BITS-1:0]  i_cfg_data
);

    localparam int W      = TYPE_BITS + HANDLE_BITS;
    localparam int NFB    = $clog2(NORMAL_DEPTH + 1);
    localparam int DFB    = $clog2(DEFERRED_DEPTH + 1);
    localparam int LBITS  = $clog2(LIST_DEPTH + 1);
    localparam int CB     = der_pkg::CAP_BITS;
    localparam int CNTB   = der_pkg::CNT_BITS;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;   // list lookup; pop issued for a take, memory data next cycle
    localparam logic [2:0] S_TAKE = 3'd2;   // take data available
    localparam logic [2:0] S_WALK = 3'd3;   // undefer: decide on next deferred event
    localparam logic [2:0] S_MOVE = 3'd4;   // undefer: popped data available
    localparam logic [2:0] S_OUT  = 3'd5;   // result waiting

    logic [2:0]             r_state, n_state;
    logic [1:0]             r_kind;
    logic [TYPE_BITS-1:0]   r_type;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [DFB-1:0]         r_left;

    logic [NFB-1:0]   r_ncap;
    logic [DFB-1:0]   r_dcap;
    logic [LBITS-1:0] r_limit;

    logic [der_pkg::STAT_BITS-1:0] r_status;
    logic                   r_went;
    logic [HANDLE_BITS-1:0] r_oh;
    logic [TYPE_BITS-1:0]   r_ot;
    logic [CNTB-1:0]        r_moved, r_dropped;

    logic n_push, n_pop, d_push, d_pop;
    logic [W-1:0] n_wdata, d_wdata, n_rdata, d_rdata;
    logic n_full, n_empty, d_full, d_empty;
    logic [NFB-1:0] n_fillv;
    logic [DFB-1:0] d_fillv;
    logic l_listed, l_full, l_append, l_remove;
    logic accept;

    // Capacity clamps, applied at reset and on a configuration write.
    function automatic logic [NFB-1:0] clamp_n(input logic [CB-1:0] v);
        if (v == '0) clamp_n = NFB'(1);
        else if (32'(v) > NORMAL_DEPTH) clamp_n = NFB'(NORMAL_DEPTH);
        else clamp_n = NFB'(v);
    endfunction
    function automatic logic [DFB-1:0] clamp_d(input logic [CB-1:0] v);
        if (v == '0) clamp_d = DFB'(1);
        else if (32'(v) > DEFERRED_DEPTH) clamp_d = DFB'(DEFERRED_DEPTH);
        else clamp_d = DFB'(v);
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);
    assign accept      = i_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncap  <= clamp_n(CB'(16));
            r_dcap  <= clamp_d(CB'(16));
            r_limit <= (LIST_DEPTH < 8) ? LBITS'(LIST_DEPTH) : LBITS'(8);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                der_pkg::CFG_NORMAL_CAP:   r_ncap <= clamp_n(i_cfg_data);
                der_pkg::CFG_DEFERRED_CAP: r_dcap <= clamp_d(i_cfg_data);
                der_pkg::CFG_LIST_LIMIT: begin
                    r_limit <= (32'(i_cfg_data[3:0]) > LIST_DEPTH) ?
                               LBITS'(LIST_DEPTH) : LBITS'(i_cfg_data[3:0]);
                end
                default: ;
            endcase
        end
    end

    der_fifo #(.DEPTH(NORMAL_DEPTH), .WIDTH(W)) u_normal (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cap(r_ncap),
        .i_push(n_push), .i_push_data(n_wdata), .i_pop(n_pop),
        .o_pop_data(n_rdata), .o_full(n_full), .o_empty(n_empty), .o_fill(n_fillv)
    );

    der_fifo #(.DEPTH(DEFERRED_DEPTH), .WIDTH(W)) u_deferred (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cap(r_dcap),
        .i_push(d_push), .i_push_data(d_wdata), .i_pop(d_pop),
        .o_pop_data(d_rdata), .o_full(d_full), .o_empty(d_empty), .o_fill(d_fillv)
    );

    // The list always sees the type held from the accepted beat.
    der_list #(.LIST_DEPTH(LIST_DEPTH), .TYPE_BITS(TYPE_BITS)) u_list (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_type(r_type), .i_limit(r_limit),
        .i_append(l_append), .i_remove(l_remove), .o_listed(l_listed), .o_full(l_full)
    );

    // Sequencer: the item is captured in IDLE and worked on from READ onwards.
    always_comb begin
        n_state  = r_state;
        n_push   = 1'b0;
        d_push   = 1'b0;
        n_pop    = 1'b0;
        d_pop    = 1'b0;
        n_wdata  = {r_handle, r_type};
        d_wdata  = {r_handle, r_type};
        l_append = 1'b0;
        l_remove = 1'b0;
        case (r_state)
            S_IDLE: if (accept) n_state = S_READ;
            S_READ: begin
                case (r_kind)
                    der_pkg::KIND_POST: begin
                        if (l_listed) d_push = !d_full;
                        else n_push = !n_full;
                        n_state = S_OUT;
                    end
                    der_pkg::KIND_DEFER: begin
                        l_append = 1'b1;
                        n_state  = S_OUT;
                    end
                    der_pkg::KIND_UNDEFER: begin
                        l_remove = 1'b1;
                        n_state  = l_listed ? S_WALK : S_OUT;
                    end
                    default: begin
                        n_pop   = !n_empty;
                        n_state = n_empty ? S_OUT : S_TAKE;
                    end
                endcase
            end
            S_TAKE: n_state = S_OUT;
            S_WALK: begin
                if (r_left == '0) begin
                    n_state = S_OUT;
                end else begin
                    d_pop   = 1'b1;
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                if (d_rdata[TYPE_BITS-1:0] == r_type) begin
                    n_push  = !n_full;
                    n_wdata = d_rdata;
                end else begin
                    d_push  = 1'b1;
                    d_wdata = d_rdata;
                end
                n_state = S_WALK;
            end
            S_OUT: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= i_kind;
            r_type    <= i_event_type;
            r_handle  <= i_event_handle;
            r_status  <= der_pkg::ST_OK;
            r_went    <= 1'b0;
            r_oh      <= '0;
            r_ot      <= '0;
            r_moved   <= '0;
            r_dropped <= '0;
        end
        case (r_state)
            S_READ: begin
                case (r_kind)
                    der_pkg::KIND_POST: begin
                        if (l_listed) begin
                            if (d_full) r_status <= der_pkg::ST_FULL;
                            else r_went <= 1'b1;
                        end else if (n_full) begin
                            r_status <= der_pkg::ST_FULL;
                        end
                    end
                    der_pkg::KIND_DEFER: begin
                        if (l_full) r_status <= der_pkg::ST_LIST_FULL;
                    end
                    der_pkg::KIND_UNDEFER: begin
                        if (!l_listed) r_status <= der_pkg::ST_NOT_LISTED;
                        r_left <= d_fillv;
                    end
                    default: begin
                        if (n_empty) r_status <= der_pkg::ST_EMPTY;
                    end
                endcase
            end
            S_TAKE: begin
                r_ot <= n_rdata[TYPE_BITS-1:0];
                r_oh <= n_rdata[W-1:TYPE_BITS];
            end
            S_WALK: if (r_left != '0) r_left <= r_left - 1'b1;
            S_MOVE: begin
                if (d_rdata[TYPE_BITS-1:0] == r_type) begin
                    if (n_full) r_dropped <= der_pkg::sat_inc(r_dropped);
                    else r_moved <= der_pkg::sat_inc(r_moved);
                end
            end
            default: ;
        endcase
    end

    assign o_valid         = (r_state == S_OUT);
    assign o_status        = r_status;
    assign o_went_deferred = r_went;
    assign o_out_handle    = r_oh;
    assign o_out_type      = r_ot;
    assign o_moved_count   = r_moved;
    assign o_dropped_count = r_dropped;

endmodule

// ===== rtl/der_checker.sv =====
// Port-level checker for the deferred event router, bound to the top level.
// Depends on der_pkg and deferred_event_router.
module der_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_status,
    input logic       o_went_deferred
);

    // Results stay while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("result changed while stalled");

    // A result is never offered at the edge an input beat is taken.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result pending");

    // Deferred placement is only reported with status ok.
    a_went: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_went_deferred |-> o_status == der_pkg::ST_OK)
        else $error("deferred flag with error status");

    // After an accepted beat the block is busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("block not busy after accept");

endmodule

bind deferred_event_router der_checker u_der_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
    .o_went_deferred(o_went_deferred)
);
